// ----- rtl/spap_pkg.sv -----
package spap_pkg;

  localparam int DEG_FOLD  = 540;
  localparam int DEG_TURN  = 360;
  localparam int DEG_HALF  = 180;

  localparam int PHASE_TICKS_RESET = 1;
  localparam int STEPS_PER_TURN_RESET = 513;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TICKS    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_TURN = 1'b1;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_MOVE = 1'b1;

  // floor(n / 45) == (n * DIV45_MAGIC) >> DIV45_SHIFT for every n < 2**17
  localparam logic [17:0] DIV45_MAGIC = 18'd186414;
  localparam int DIV45_SHIFT = 23;

  typedef struct packed {
    logic       func;
    logic [8:0] target_deg;
  } item_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       busy_res;
    logic [8:0] position_deg;
    logic       rejected;
  } res_t;

  // product of |difference| and steps_per_turn, divided by 360
  function automatic logic [11:0] steps_of(input logic [19:0] prod);
    logic [34:0] scaled;
    begin
      scaled = 35'(prod[19:3]) * 35'(DIV45_MAGIC);
      steps_of = scaled[DIV45_SHIFT +: 12];
    end
  endfunction

endpackage

// ----- rtl/spap_in_stage.sv -----
module spap_in_stage import spap_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  hold_valid,
  output item_t hold_item
);

  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

// ----- rtl/spap_engine.sv -----
module spap_engine import spap_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   fire,
  input  item_t                  item,
  output res_t                   res
);

  logic [7:0]  phase_ticks;
  logic [11:0] steps_per_turn;

  logic [8:0]  position,    position_next;
  logic [11:0] steps_left,  steps_left_next;
  logic [1:0]  phase_index, phase_index_next;
  logic        turn_dir,    turn_dir_next;
  logic [7:0]  tick_count,  tick_count_next;
  logic        running,     running_next;
  logic        div_pending, div_pending_next;
  logic [19:0] prod_q,      prod_q_next;

  logic [3:0]  coil_now;
  logic [7:0]  limit;
  logic [8:0]  tick_inc;
  logic [10:0] diff_raw;
  logic [8:0]  folded;
  logic [8:0]  target_mod;
  logic [7:0]  mag;
  logic        dir_ccw;
  logic [19:0] prod;
  logic [11:0] steps_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks    <= 8'(PHASE_TICKS_RESET);
      steps_per_turn <= 12'(STEPS_PER_TURN_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_TICKS:    phase_ticks    <= cfg_data[7:0];
        REG_STEPS_PER_TURN: steps_per_turn <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!running) begin
      coil_now = 4'b0000;
    end else if (turn_dir) begin
      coil_now = 4'b1000 >> phase_index;
    end else begin
      coil_now = 4'b0001 << phase_index;
    end
  end

  // shortest move: fold into 0..359, where folded stands for difference + 180
  always_comb begin
    diff_raw = 11'(item.target_deg) + 11'(DEG_FOLD) - 11'(position);
    if (diff_raw >= 11'(2 * DEG_TURN)) begin
      folded = 9'(diff_raw - 11'(2 * DEG_TURN));
    end else if (diff_raw >= 11'(DEG_TURN)) begin
      folded = 9'(diff_raw - 11'(DEG_TURN));
    end else begin
      folded = 9'(diff_raw);
    end
    if (folded >= 9'(DEG_HALF)) begin
      mag     = 8'(folded - 9'(DEG_HALF));
      dir_ccw = 1'b0;
    end else begin
      mag     = 8'(9'(DEG_HALF) - folded);
      dir_ccw = 1'b1;
    end
    target_mod = (item.target_deg >= 9'(DEG_TURN)) ?
                 9'(item.target_deg - 9'(DEG_TURN)) : item.target_deg;
    prod = 20'(mag) * 20'(steps_per_turn);
  end

  always_comb begin
    limit     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    tick_inc  = 9'(tick_count) + 9'd1;
    steps_dec = (steps_left != 12'd0) ? steps_left - 12'd1 : steps_left;

    position_next    = position;
    steps_left_next  = div_pending ? steps_of(prod_q) : steps_left;
    phase_index_next = phase_index;
    turn_dir_next    = turn_dir;
    tick_count_next  = tick_count;
    running_next     = running;
    div_pending_next = 1'b0;
    prod_q_next      = prod_q;

    res.coils    = 4'b0000;
    res.rejected = 1'b0;

    if (fire) begin
      if (item.func == FUNC_TICK) begin
        res.coils = coil_now;
        if (running) begin
          if (tick_inc >= 9'(limit)) begin
            tick_count_next = 8'd0;
            if (phase_index == 2'd3) begin
              phase_index_next = 2'd0;
              steps_left_next  = steps_dec;
              running_next     = (steps_dec != 12'd0);
            end else begin
              phase_index_next = phase_index + 2'd1;
            end
          end else begin
            tick_count_next = tick_inc[7:0];
          end
        end
      end else if (running) begin
        res.coils    = coil_now;
        res.rejected = 1'b1;
      end else begin
        // step count is settled in the next cycle, before any step can end
        position_next    = target_mod;
        turn_dir_next    = dir_ccw;
        phase_index_next = 2'd0;
        tick_count_next  = 8'd0;
        running_next     = (prod >= 20'(DEG_TURN));
        prod_q_next      = prod;
        div_pending_next = 1'b1;
      end
    end

    res.busy_res     = running_next;
    res.position_deg = position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= 9'd0;
      steps_left  <= 12'd0;
      phase_index <= 2'd0;
      turn_dir    <= 1'b0;
      tick_count  <= 8'd0;
      running     <= 1'b0;
      div_pending <= 1'b0;
    end else begin
      position    <= position_next;
      steps_left  <= steps_left_next;
      phase_index <= phase_index_next;
      turn_dir    <= turn_dir_next;
      tick_count  <= tick_count_next;
      running     <= running_next;
      div_pending <= div_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    prod_q <= prod_q_next;
  end

endmodule

// ----- rtl/spap_out_stage.sv -----
module spap_out_stage import spap_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic hold_valid,
  input  res_t res_in,
  input  logic out_ready,
  output logic advance,
  output logic out_valid,
  output res_t res_out
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      res_out <= res_in;
    end
  end

endmodule

// ----- rtl/stepper_shortest_angle_positioner_core.sv -----
// Shortest-angle stepper positioner with wave-drive coil output.
// Input channel (in_valid/in_ready): func 0 is a time tick, func 1 a move
// command to target_deg. Each input beat gives exactly one output beat
// (out_valid/out_ready) carrying coils, busy_res, position_deg and rejected.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = phase_ticks, 1 = steps_per_turn) at the clock edge, no handshake;
// write only while the block is idle.
// Path: input register, then result register, which offers the beat.
// Throughput: one beat per cycle while out_ready is high, set by the
// single state-update stage between the input and result registers.
// The step count of a move is finished by a reciprocal multiplier in the
// cycle after the command, ahead of the first possible step end.
// Reset (rst, synchronous): position 0, idle, coils off, phase_ticks 1,
// steps_per_turn 513; both stages empty.
// When out_ready is low the result register holds its beat; the input
// register still takes one more beat, then in_ready drops until the
// receiver drains.
module stepper_shortest_angle_positioner_core import spap_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic [8:0]             target_deg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             coils,
  output logic                   busy_res,
  output logic [8:0]             position_deg,
  output logic                   rejected
);

  item_t in_item;
  item_t hold_item;
  logic  hold_valid;
  logic  advance;
  res_t  res_now;
  res_t  res_reg;

  assign in_item.func       = func;
  assign in_item.target_deg = target_deg;

  spap_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  spap_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (hold_valid && advance),
    .item      (hold_item),
    .res       (res_now)
  );

  spap_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .res_in     (res_now),
    .out_ready  (out_ready),
    .advance    (advance),
    .out_valid  (out_valid),
    .res_out    (res_reg)
  );

  assign coils        = res_reg.coils;
  assign busy_res     = res_reg.busy_res;
  assign position_deg = res_reg.position_deg;
  assign rejected     = res_reg.rejected;

endmodule
